>>> rtl/hslrgb_pkg.sv
`timescale 1ns / 1ps

package hslrgb_pkg;

   // load enables for the four pipeline stages, driven by the top-level ready chain
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

>>> rtl/hslrgb_levels.sv
`timescale 1ns / 1ps

// Helper levels: stage 1 clamps and multiplies, stage 2 forms high, low and their spread.
module hslrgb_levels import hslrgb_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  logic                 clock,
   input  stage_en_type         en,
   input  logic [FRAC_BITS:0]   sat,
   input  logic [FRAC_BITS:0]   lit,
   output logic [FRAC_BITS:0]   high_level,
   output logic [FRAC_BITS:0]   low_level,
   output logic [FRAC_BITS:0]   diff_level
);

   localparam int W = FRAC_BITS + 1;
   localparam logic [W-1:0] ONE_V  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [W-1:0] HALF_V = ONE_V >> 1;
   localparam logic [W+1:0] ONE_X  = {2'b00, ONE_V};

   logic [W-1:0]   s_c;
   logic [W-1:0]   l_c;
   logic           small_in;
   logic [W:0]     mul_b;
   logic [2*W:0]   prod_in;

   logic [2*W:0]   prod_ff;
   logic [W-1:0]   l_ff;
   logic [W-1:0]   s_ff;
   logic           small_ff;

   logic [W:0]     prod_sh;
   logic [W+1:0]   hi_a;
   logic [W-1:0]   hi_c;
   logic signed [W+1:0] lo_s;
   logic [W-1:0]   lo_c;
   logic [W-1:0]   diff_c;

   logic [W-1:0]   high_ff;
   logic [W-1:0]   low_ff;
   logic [W-1:0]   diff_ff;

   // stage 1
   always_comb begin
      s_c      = (sat > ONE_V) ? ONE_V : sat;
      l_c      = (lit > ONE_V) ? ONE_V : lit;
      small_in = (l_c < HALF_V);
      mul_b    = small_in ? ({1'b0, ONE_V} + {1'b0, s_c}) : {1'b0, s_c};
      prod_in  = l_c * mul_b;
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff  <= prod_in;
         l_ff     <= l_c;
         s_ff     <= s_c;
         small_ff <= small_in;
      end
   end

   // stage 2
   always_comb begin
      prod_sh = prod_ff[FRAC_BITS +: W+1];
      if (small_ff) begin
         hi_a = {1'b0, prod_sh};
      end else begin
         hi_a = {2'b00, l_ff} + {2'b00, s_ff} - {1'b0, prod_sh};
      end
      hi_c = (hi_a > ONE_X) ? ONE_V : hi_a[W-1:0];
      lo_s = $signed({1'b0, l_ff, 1'b0}) - $signed({2'b00, hi_c});
      if (lo_s < 0) begin
         lo_c = '0;
      end else if (lo_s > $signed(ONE_X)) begin
         lo_c = ONE_V;
      end else begin
         lo_c = lo_s[W-1:0];
      end
      diff_c = (hi_c > lo_c) ? (hi_c - lo_c) : '0;
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         high_ff <= hi_c;
         low_ff  <= lo_c;
         diff_ff <= diff_c;
      end
   end

   assign high_level = high_ff;
   assign low_level  = low_ff;
   assign diff_level = diff_ff;

endmodule

>>> rtl/hslrgb_channel.sv
`timescale 1ns / 1ps

// One channel of the curve: region decode, ramp multiply, level select and byte scaling.
module hslrgb_channel import hslrgb_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  logic                 clock,
   input  stage_en_type         en,
   input  logic [FRAC_BITS-1:0] hue,
   input  logic [FRAC_BITS:0]   high_level,
   input  logic [FRAC_BITS:0]   low_level,
   input  logic [FRAC_BITS:0]   diff_level,
   output logic [7:0]           level
);

   typedef enum logic [1:0] {
      REG_RISE = 2'd0,
      REG_HIGH = 2'd1,
      REG_FALL = 2'd2,
      REG_LOW  = 2'd3
   } region_type;

   localparam int W  = FRAC_BITS + 1;
   localparam int MW = FRAC_BITS + 3;
   localparam int TT = (4 * (1 << FRAC_BITS) + 3) / 6;
   localparam logic [FRAC_BITS-1:0] TT_V  = FRAC_BITS'(TT);
   localparam logic [W-1:0]         ONE_V = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [MW-1:0]        ONE_X = {2'b00, ONE_V};
   localparam logic [MW-1:0]        TWO_X = ONE_X << 1;

   logic [MW-1:0]        h6;
   logic [MW-1:0]        h3;
   logic [MW-1:0]        h2;
   logic [FRAC_BITS-1:0] span;
   region_type           region_in;
   logic [MW-1:0]        m_in;

   region_type           region1_ff;
   logic [MW-1:0]        m1_ff;
   region_type           region2_ff;
   logic [MW-1:0]        m2_ff;

   logic [W+MW-1:0]      prod_in;
   logic [W+MW-1:0]      prod_ff;
   region_type           region3_ff;
   logic [W-1:0]         high3_ff;
   logic [W-1:0]         low3_ff;

   logic [MW:0]          ramp;
   logic [MW+1:0]        lvl_sum;
   logic [MW+1:0]        lvl_sel;
   logic [W-1:0]         lvl_c;
   logic [W+7:0]         scaled;
   logic [8:0]           byte_raw;
   logic [7:0]           level_in;
   logic [7:0]           level_ff;

   // stage 1: region and ramp factor
   always_comb begin
      h6   = {3'b000, hue} * 3'd6;
      h3   = {3'b000, hue} * 2'd3;
      h2   = {2'b00, hue, 1'b0};
      span = (hue >= TT_V) ? '0 : (TT_V - hue);
      priority if (h6 < ONE_X) begin
         region_in = REG_RISE;
         m_in      = h6;
      end else if (h2 < ONE_X) begin
         region_in = REG_HIGH;
         m_in      = '0;
      end else if (h3 < TWO_X) begin
         region_in = REG_FALL;
         m_in      = {3'b000, span} * 3'd6;
      end else begin
         region_in = REG_LOW;
         m_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         region1_ff <= region_in;
         m1_ff      <= m_in;
      end
   end

   // stage 2: wait for the helper levels
   always_ff @(posedge clock) begin
      if (en.s2) begin
         region2_ff <= region1_ff;
         m2_ff      <= m1_ff;
      end
   end

   // stage 3: spread times ramp factor
   assign prod_in = diff_level * m2_ff;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         prod_ff    <= prod_in;
         region3_ff <= region2_ff;
         high3_ff   <= high_level;
         low3_ff    <= low_level;
      end
   end

   // stage 4: level, clamp, scale by 255 as (x << 8) - x
   always_comb begin
      ramp    = prod_ff[FRAC_BITS +: MW+1];
      lvl_sum = {{(MW+2-W){1'b0}}, low3_ff} + {1'b0, ramp};
      unique case (region3_ff)
         REG_RISE, REG_FALL: lvl_sel = lvl_sum;
         REG_HIGH:           lvl_sel = {{(MW+2-W){1'b0}}, high3_ff};
         REG_LOW:            lvl_sel = {{(MW+2-W){1'b0}}, low3_ff};
         default:            lvl_sel = {{(MW+2-W){1'b0}}, low3_ff};
      endcase
      lvl_c    = (lvl_sel > {{(MW+2-W){1'b0}}, ONE_V}) ? ONE_V : lvl_sel[W-1:0];
      scaled   = {lvl_c, 8'h00} - {8'h00, lvl_c};
      byte_raw = scaled[FRAC_BITS +: 9];
      level_in = byte_raw[8] ? 8'hFF : byte_raw[7:0];
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

>>> rtl/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// Pipeline: four register stages; an accepted item moves through s1, s2, s3 and s4, then rsp_valid rises.
// Throughput: one item per cycle while rsp_ready is not held low; each of the four register stages holds one item.
// Stalls: every stage loads when it is empty or its successor moves, so bubbles close up.
// Reset: synchronous, active high; clears the stage valid bits only, datapath is not reset.
module hsl_to_rgb_converter import hslrgb_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [FRAC_BITS-1:0] req_hue,
   input  logic [FRAC_BITS:0]   req_saturation,
   input  logic [FRAC_BITS:0]   req_lightness,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_red_level,
   output logic [7:0]           rsp_green_level,
   output logic [7:0]           rsp_blue_level
);

   // One third of a turn, rounded, in hue units. Hue wraps by plain truncation.
   localparam int THIRD = (2 * (1 << FRAC_BITS) + 3) / 6;
   localparam logic [FRAC_BITS-1:0] THIRD_V = FRAC_BITS'(THIRD);

   // Pipeline map:
   //   s1: clamp S/L, L*(ONE+S) or L*S; per channel region decode and ramp factor
   //   s2: high/low helper levels; channel data waits alongside
   //   s3: per channel spread * ramp factor
   //   s4: level select and clamp, *255 >> FRAC_BITS, output register
   logic [3:0]           valid_ff;
   logic [3:0]           valid_in;
   logic [3:0]           stage_rdy;
   stage_en_type         en;

   logic [FRAC_BITS-1:0] hue_red;
   logic [FRAC_BITS-1:0] hue_blue;
   logic [FRAC_BITS:0]   high_level;
   logic [FRAC_BITS:0]   low_level;
   logic [FRAC_BITS:0]   diff_level;

   // Ready chain: a stage may load when it is empty or its content moves on.
   always_comb begin
      stage_rdy[3] = !valid_ff[3] || rsp_ready;
      stage_rdy[2] = !valid_ff[2] || stage_rdy[3];
      stage_rdy[1] = !valid_ff[1] || stage_rdy[2];
      stage_rdy[0] = !valid_ff[0] || stage_rdy[1];
   end

   assign en.s1 = stage_rdy[0];
   assign en.s2 = stage_rdy[1];
   assign en.s3 = stage_rdy[2];
   assign en.s4 = stage_rdy[3];

   assign req_ready = stage_rdy[0];
   assign rsp_valid = valid_ff[3];

   always_comb begin
      valid_in[0] = stage_rdy[0] ? req_valid   : valid_ff[0];
      valid_in[1] = stage_rdy[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = stage_rdy[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = stage_rdy[3] ? valid_ff[2] : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Red sees the hue a third ahead, blue a third behind, both modulo one turn.
   assign hue_red  = req_hue + THIRD_V;
   assign hue_blue = req_hue - THIRD_V;

   hslrgb_levels #(
      .FRAC_BITS (FRAC_BITS)
   ) u_levels (
      .clock      (clock),
      .en         (en),
      .sat        (req_saturation),
      .lit        (req_lightness),
      .high_level (high_level),
      .low_level  (low_level),
      .diff_level (diff_level)
   );

   hslrgb_channel #(
      .FRAC_BITS (FRAC_BITS)
   ) u_red (
      .clock      (clock),
      .en         (en),
      .hue        (hue_red),
      .high_level (high_level),
      .low_level  (low_level),
      .diff_level (diff_level),
      .level      (rsp_red_level)
   );

   hslrgb_channel #(
      .FRAC_BITS (FRAC_BITS)
   ) u_green (
      .clock      (clock),
      .en         (en),
      .hue        (req_hue),
      .high_level (high_level),
      .low_level  (low_level),
      .diff_level (diff_level),
      .level      (rsp_green_level)
   );

   hslrgb_channel #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blue (
      .clock      (clock),
      .en         (en),
      .hue        (hue_blue),
      .high_level (high_level),
      .low_level  (low_level),
      .diff_level (diff_level),
      .level      (rsp_blue_level)
   );

`ifndef SYNTHESIS
   // Output side able to drain means the input side is open.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while output drains");

   // Input only closes when every stage holds an item.
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (valid_ff == 4'b1111))
      else $error("input stalled with a bubble in the pipeline");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

>>> tb/sv/hsl_to_rgb_converter_test.sv
`timescale 1ns / 1ps

module hsl_to_rgb_converter_test;

   localparam int FRAC_BITS  = 12;
   localparam int ONE        = 1 << FRAC_BITS;
   // thirds of a turn, rounded to nearest in Q0.12
   localparam int THIRD      = (2 * ONE + 3) / 6;
   localparam int TWO_THIRDS = (4 * ONE + 3) / 6;
   localparam int RANDOM_ITEMS = 400;
   localparam int CALM_TAIL    = 60;    // last items go through with no idling
   localparam int STALL_LIMIT  = 2000;  // cycles without any handshake

   typedef struct packed {
      logic [FRAC_BITS-1:0] hue;
      logic [FRAC_BITS:0]   saturation;
      logic [FRAC_BITS:0]   lightness;
   } hsl_item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [FRAC_BITS-1:0] req_hue = '0;
   logic [FRAC_BITS:0]   req_saturation = '0;
   logic [FRAC_BITS:0]   req_lightness = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_red_level;
   logic [7:0]           rsp_green_level;
   logic [7:0]           rsp_blue_level;

   hsl_item_type pending_colors[$];   // stimulus not yet offered
   rgb_item_type expected_colors[$];  // predicted pixels, oldest first
   int        mismatches = 0;
   int        send_gap = 0;
   int        stall_left = 0;
   int        quiet_cycles = 0;

   hsl_to_rgb_converter #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red_level  (rsp_red_level),
      .rsp_green_level(rsp_green_level),
      .rsp_blue_level (rsp_blue_level)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Golden conversion
   // ---------------------------------------------------------------

   function automatic longint clamp_unit(longint v);
      if (v < 0) return 0;
      if (v > ONE) return ONE;
      return v;
   endfunction

   // Piecewise-linear channel curve: rise over the first sixth, flat top
   // to one half, fall to two thirds, floor for the rest of the turn.
   function automatic longint curve_level(longint h, longint high, longint low);
      longint d;
      longint lvl;
      longint span;
      d = high - low;
      if (d < 0) d = 0;
      if (6 * h < ONE) begin
         lvl = low + ((d * 6 * h) >>> FRAC_BITS);
      end else if (2 * h < ONE) begin
         lvl = high;
      end else if (3 * h < 2 * ONE) begin
         span = TWO_THIRDS - h;
         if (span < 0) span = 0;
         lvl = low + ((d * 6 * span) >>> FRAC_BITS);
      end else begin
         lvl = low;
      end
      return clamp_unit(lvl);
   endfunction

   function automatic logic [7:0] level_to_byte(longint lvl);
      longint v;
      v = (lvl * 255) >>> FRAC_BITS;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic rgb_item_type rgb_from_hsl(hsl_item_type c);
      longint h;
      longint s;
      longint l;
      longint high;
      longint low;
      rgb_item_type px;
      h = c.hue;
      s = clamp_unit(c.saturation);   // values above 1.0 saturate
      l = clamp_unit(c.lightness);
      if (2 * l < ONE) high = (l * (ONE + s)) >>> FRAC_BITS;
      else high = l + s - ((l * s) >>> FRAC_BITS);
      high = clamp_unit(high);
      low  = clamp_unit(2 * l - high);
      px.red   = level_to_byte(curve_level((h + THIRD) % ONE, high, low));
      px.green = level_to_byte(curve_level(h, high, low));
      px.blue  = level_to_byte(curve_level((h + ONE - THIRD) % ONE, high, low));
      return px;
   endfunction

   task automatic add_color(int h, int s, int l);
      hsl_item_type c;
      c.hue        = h[FRAC_BITS-1:0];
      c.saturation = s[FRAC_BITS:0];
      c.lightness  = l[FRAC_BITS:0];
      pending_colors.push_back(c);
   endtask

   function automatic int pick_unit_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return $urandom_range(0, ONE);
      if (roll < 8) return $urandom_range(ONE + 1, 2 * ONE - 1);  // above 1.0
      case ($urandom_range(0, 3))
         0: return 0;
         1: return ONE;
         2: return ONE / 2 - 1;
         default: return ONE / 2;
      endcase
   endfunction

   function automatic int pick_hue();
      // some hues land right on a region edge of one of the channels
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 5))
            0: return 682 + $urandom_range(0, 1);
            1: return 2047 + $urandom_range(0, 1);
            2: return 2730 + $urandom_range(0, 1);
            3: return THIRD + $urandom_range(0, 1) - 1;
            4: return ONE - 1;
            default: return 0;
         endcase
      end
      return $urandom_range(0, ONE - 1);
   endfunction

   // ---------------------------------------------------------------
   // Driver: offers queued colors, with random idle bursts
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      hsl_item_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            c.hue        = req_hue;
            c.saturation = req_saturation;
            c.lightness  = req_lightness;
            expected_colors.push_back(rgb_from_hsl(c));
         end
         // the channel is free once the current item is taken or none is up
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_colors.size() > 0) begin
               c = pending_colors.pop_front();
               req_hue        <= c.hue;
               req_saturation <= c.saturation;
               req_lightness  <= c.lightness;
               req_valid      <= 1'b1;
               if (pending_colors.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
                  send_gap = $urandom_range(1, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: takes pixels, with random backpressure bursts, and
   // checks each against the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rgb_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
               $error("unexpected pixel r=%0d g=%0d b=%0d",
                      rsp_red_level, rsp_green_level, rsp_blue_level);
               mismatches++;
            end else begin
               want = expected_colors.pop_front();
               if (rsp_red_level !== want.red) begin
                  $error("red_level: expected %0d, got %0d", want.red, rsp_red_level);
                  mismatches++;
               end
               if (rsp_green_level !== want.green) begin
                  $error("green_level: expected %0d, got %0d", want.green, rsp_green_level);
                  mismatches++;
               end
               if (rsp_blue_level !== want.blue) begin
                  $error("blue_level: expected %0d, got %0d", want.blue, rsp_blue_level);
                  mismatches++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (pending_colors.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
               stall_left = $urandom_range(1, 19);
         end
      end
   end

   // Watchdog: no handshake on either side for too long means a hang
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      // primaries and the top of the hue range at full saturation, mid lightness
      add_color(0, 4096, 2048);
      add_color(THIRD, 4096, 2048);       // blue hue wraps exactly to zero
      add_color(TWO_THIRDS, 4096, 2048);  // red hue wraps one full turn
      add_color(ONE - 1, 4096, 2048);
      // curve region edges
      add_color(682, 4096, 2048);
      add_color(683, 4096, 2048);
      add_color(2047, 3000, 2048);
      add_color(2048, 3000, 2048);
      add_color(2730, 4096, 1500);
      add_color(2731, 4096, 1500);
      // grey: no saturation
      add_color(1000, 0, 3000);
      add_color(3000, 0, 1000);
      add_color(0, 0, 0);
      // lightness either side of one half, black and white
      add_color(1234, 2048, 2047);
      add_color(1234, 2048, 2048);
      add_color(100, 4096, 4096);
      add_color(3500, 4096, 0);
      // out-of-range saturation and lightness clip to 1.0
      add_color(500, 8191, 1000);
      add_color(2000, 3000, 8191);
      add_color(ONE - 1, 8191, 8191);
      add_color(2500, 5000, 5000);
      add_color(1, 1, 1);
      repeat (RANDOM_ITEMS) add_color(pick_hue(), pick_unit_value(), pick_unit_value());

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_colors.size() != 0 || req_valid || expected_colors.size() != 0)
         @(posedge clock);
      // pipeline is four deep; give stray pixels a chance to show up
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/hslrgb_pkg.sv
rtl/hslrgb_levels.sv
rtl/hslrgb_channel.sv
rtl/hsl_to_rgb_converter.sv
tb/sv/hsl_to_rgb_converter_test.sv
